FILE: sv/bmpcrop_pkg.sv
// Shared types and constants for the BMP row crop block.
package bmpcrop_pkg;

    // Fixed register field widths.
    localparam int DIM_W = 13;  // source and window dimensions
    localparam int POS_W = 12;  // window left and top
    localparam int LIN_W = 16;  // byte position within a row, holds 3 * (2**DIM_W - 1)
    localparam int CFG_ADDR_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_WINDOW_LEFT   = 3'd2,
        CFG_WINDOW_TOP    = 3'd3,
        CFG_WINDOW_WIDTH  = 3'd4,
        CFG_WINDOW_HEIGHT = 3'd5
    } cfg_reg_e;

    // One forwarded window byte plus the padding that may follow it.
    typedef struct packed {
        logic [7:0] data;      // source pixel byte
        logic       last;      // last pixel byte of its output row
        logic [1:0] npad;      // output row padding count
        logic       img;       // row is the last output row of the image
    } crop_item_t;

endpackage

FILE: sv/bmpcrop_locate.sv
// Window decode: decides whether a source byte lies inside the clipped crop window.
module bmpcrop_locate import bmpcrop_pkg::*; #(
    parameter int BIR_W = 14,
    parameter int ROW_W = 12
) (
    input  logic [DIM_W-1:0] src_w,
    input  logic [DIM_W-1:0] src_h,
    input  logic [POS_W-1:0] win_x,
    input  logic [POS_W-1:0] win_y,
    input  logic [DIM_W-1:0] win_w,
    input  logic [DIM_W-1:0] win_h,
    input  logic [BIR_W-1:0] byte_pos,
    input  logic [ROW_W-1:0] row,
    input  logic [7:0]       data,
    output logic             hit,
    output crop_item_t       item
);

    logic [DIM_W-1:0] room;
    logic [DIM_W-1:0] ew;
    logic             rows_ok;
    logic [DIM_W:0]   y_ext;
    logic [DIM_W:0]   h_ext;
    logic [DIM_W:0]   y_plus_h;
    logic [DIM_W:0]   hi;
    logic [DIM_W:0]   lo;
    logic [DIM_W:0]   row_ext;
    logic [LIN_W-1:0] first;
    logic [LIN_W-1:0] span;
    logic [LIN_W-1:0] last;
    logic [LIN_W-1:0] pos_ext;

    always_comb begin
        // Clip window width against the source.
        room = src_w - DIM_W'(win_x);
        if (DIM_W'(win_x) >= src_w) begin
            ew = '0;
        end else if (win_w < room) begin
            ew = win_w;
        end else begin
            ew = room;
        end

        y_ext    = (DIM_W+1)'(win_y);
        h_ext    = (DIM_W+1)'(win_h);
        y_plus_h = y_ext + h_ext;
        rows_ok  = (y_ext < (DIM_W+1)'(src_h)) && (win_h != '0) && (ew != '0);
        hi       = rows_ok ? ((DIM_W+1)'(src_h) - 1'b1 - y_ext) : '0;
        lo       = (rows_ok && (y_plus_h < (DIM_W+1)'(src_h))) ?
                   ((DIM_W+1)'(src_h) - y_plus_h) : '0;
        row_ext  = (DIM_W+1)'(row);

        // Byte span of the window inside a row: three bytes per pixel.
        first   = (LIN_W'(win_x) << 1) + LIN_W'(win_x);
        span    = LIN_W'(win_x) + LIN_W'(ew);
        last    = (span << 1) + span - 1'b1;
        pos_ext = LIN_W'(byte_pos);

        hit = rows_ok && (row_ext >= lo) && (row_ext <= hi) &&
              (pos_ext >= first) && (pos_ext <= last);

        item.data = data;
        item.last = (pos_ext == last);
        item.npad = ew[1:0];
        item.img  = (row_ext == hi);
    end

endmodule

FILE: sv/bmpcrop_pad_ser.sv
// Output stage: emits a window byte and then any inserted row padding, one per transaction.
module bmpcrop_pad_ser import bmpcrop_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  crop_item_t load_item,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_padding,
    output logic       m_row_done,
    output logic       m_image_done
);

    logic       valid_reg, valid_next;
    logic       byte_pend_reg, byte_pend_next;
    logic [1:0] pads_reg, pads_next;
    crop_item_t item_reg, item_next;
    logic       take;
    logic       final_take;
    logic       pad_end;

    always_comb begin
        take       = valid_reg && m_ready;
        final_take = take && ((byte_pend_reg && (pads_reg == 2'd0)) ||
                              (!byte_pend_reg && (pads_reg == 2'd1)));
        free       = !valid_reg || final_take;
        pad_end    = (pads_reg == 2'd1);

        m_valid = valid_reg;
        if (byte_pend_reg) begin
            m_out_byte   = item_reg.data;
            m_is_padding = 1'b0;
            m_row_done   = (pads_reg == 2'd0) && item_reg.last;
            m_image_done = (pads_reg == 2'd0) && item_reg.last && item_reg.img;
        end else begin
            m_out_byte   = '0;
            m_is_padding = 1'b1;
            m_row_done   = pad_end;
            m_image_done = pad_end && item_reg.img;
        end

        valid_next     = valid_reg;
        byte_pend_next = byte_pend_reg;
        pads_next      = pads_reg;
        item_next      = item_reg;
        if (take) begin
            if (byte_pend_reg) begin
                byte_pend_next = 1'b0;
            end else begin
                pads_next = pads_reg - 2'd1;
            end
            if (final_take) begin
                valid_next = 1'b0;
            end
        end
        if (load) begin
            valid_next     = 1'b1;
            byte_pend_next = 1'b1;
            pads_next      = load_item.last ? load_item.npad : 2'd0;
            item_next      = load_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            byte_pend_reg <= 1'b0;
            pads_reg      <= 2'd0;
        end else begin
            valid_reg     <= valid_next;
            byte_pend_reg <= byte_pend_next;
            pads_reg      <= pads_next;
        end
        item_reg <= item_next;
    end

endmodule

FILE: sv/bmp_row_padded_crop.sv
// Top level of the streaming crop for bottom-up 24-bit BMP pixel data.
//
// Feed the pixel data of a bottom-up 24-bit BMP one byte per input transaction in
// storage order, source row padding included; assert s_frame_start on the first byte
// of an image to restart the row and byte counters there. The block passes on the
// bytes that fall inside the crop window (window_top counted from the image top,
// clipped against the source), appends (clipped width mod 4) zero bytes after each
// output row, and flags the last byte of each output row and of the image. Input
// accepts one byte per cycle unless stalled; a window byte that ends an output row
// holds the output register while its padding bytes go out, so the input stalls
// only while the two-entry buffer (input register plus output register) is full.
// Bytes pass the input register, then the output register. Write configuration
// through the cfg_ channel only while the stream is idle; registers reset to a 1 x 1
// source and a 1 x 1 window at the origin, and there is no clearing pass after reset.
module bmp_row_padded_crop import bmpcrop_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]      cfg_data,
    // source byte stream
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_pixel_byte,
    input  logic                  s_frame_start,
    // cropped byte stream
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_is_padding,
    output logic                  m_row_done,
    output logic                  m_image_done
);

    // Dimension limits, capped at what the register fields can hold.
    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int WCAP    = (MAX_WIDTH  < DIM_MAX) ? MAX_WIDTH  : DIM_MAX;
    localparam int HCAP    = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int BIR_W   = $clog2(3 * WCAP + 4);
    localparam int ROW_W   = $clog2(HCAP);

    // Configuration registers.
    logic [DIM_W-1:0] src_w_reg, src_h_reg, win_w_reg, win_h_reg;
    logic [POS_W-1:0] win_x_reg, win_y_reg;

    // Position counters.
    logic [BIR_W-1:0] bir_reg, bir_next, bir_base;
    logic [ROW_W-1:0] row_reg, row_next, row_base;
    logic [BIR_W:0]   bir_inc;
    logic [DIM_W:0]   row_inc;

    // Clamped source dimensions and the stored row length.
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [BIR_W-1:0] row_bytes;

    // Input register stage.
    logic       a_valid_reg, a_valid_next;
    crop_item_t a_item_reg, a_item_next;

    logic       s_take;
    logic       hit;
    crop_item_t hit_item;
    logic       ser_free;
    logic       ser_load;

    assign cfg_ready = 1'b1;

    // Register writes; indexes beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= DIM_W'(1);
            src_h_reg <= DIM_W'(1);
            win_x_reg <= '0;
            win_y_reg <= '0;
            win_w_reg <= DIM_W'(1);
            win_h_reg <= DIM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                CFG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                CFG_WINDOW_LEFT:   win_x_reg <= cfg_data[POS_W-1:0];
                CFG_WINDOW_TOP:    win_y_reg <= cfg_data[POS_W-1:0];
                CFG_WINDOW_WIDTH:  win_w_reg <= cfg_data;
                CFG_WINDOW_HEIGHT: win_h_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // Treat zero as one and saturate at the limit.
        if (src_w_reg == '0) begin
            src_w = DIM_W'(1);
        end else if (src_w_reg > DIM_W'(WCAP)) begin
            src_w = DIM_W'(WCAP);
        end else begin
            src_w = src_w_reg;
        end
        if (src_h_reg == '0) begin
            src_h = DIM_W'(1);
        end else if (src_h_reg > DIM_W'(HCAP)) begin
            src_h = DIM_W'(HCAP);
        end else begin
            src_h = src_h_reg;
        end
        // Three bytes per pixel plus the source row padding.
        row_bytes = (BIR_W'(src_w) << 1) + BIR_W'(src_w) + BIR_W'(src_w[1:0]);
    end

    // Input side: accept while the input register is empty or drains this cycle.
    assign s_ready  = !a_valid_reg || ser_free;
    assign s_take   = s_valid && s_ready;
    assign ser_load = a_valid_reg && ser_free;

    // Frame start restarts the counters at this very byte.
    assign bir_base = s_frame_start ? '0 : bir_reg;
    assign row_base = s_frame_start ? '0 : row_reg;

    bmpcrop_locate #(
        .BIR_W (BIR_W),
        .ROW_W (ROW_W)
    ) u_locate (
        .src_w    (src_w),
        .src_h    (src_h),
        .win_x    (win_x_reg),
        .win_y    (win_y_reg),
        .win_w    (win_w_reg),
        .win_h    (win_h_reg),
        .byte_pos (bir_base),
        .row      (row_base),
        .data     (s_pixel_byte),
        .hit      (hit),
        .item     (hit_item)
    );

    always_comb begin
        // Advance the byte counter; wrap rows, then the whole image.
        bir_inc  = (BIR_W+1)'(bir_base) + 1'b1;
        row_inc  = (DIM_W+1)'(row_base) + 1'b1;
        bir_next = bir_reg;
        row_next = row_reg;
        if (s_take) begin
            if (bir_inc >= (BIR_W+1)'(row_bytes)) begin
                bir_next = '0;
                if (row_inc >= (DIM_W+1)'(src_h)) begin
                    row_next = '0;
                end else begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end else begin
                bir_next = bir_inc[BIR_W-1:0];
                row_next = row_base;
            end
        end

        // Hold a window byte in the input register; drop bytes outside the window.
        a_valid_next = a_valid_reg;
        a_item_next  = a_item_reg;
        if (ser_load) begin
            a_valid_next = 1'b0;
        end
        if (s_take) begin
            a_valid_next = hit;
            a_item_next  = hit_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bir_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            bir_reg     <= bir_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
        end
        a_item_reg <= a_item_next;
    end

    bmpcrop_pad_ser u_pad_ser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (ser_load),
        .load_item    (a_item_reg),
        .free         (ser_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_padding (m_is_padding),
        .m_row_done   (m_row_done),
        .m_image_done (m_image_done)
    );

    // End of image always closes a row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_done |-> m_row_done)
        else $error("image end without row end");

    // Inserted padding carries zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_padding |-> (m_out_byte == 8'd0))
        else $error("padding byte not zero");

    // A blocked input register keeps its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !ser_free |=> a_valid_reg && $stable(a_item_reg))
        else $error("input register lost a held item");

    // The row counter stays inside the height limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> ((DIM_W+1)'(row_reg) < (DIM_W+1)'(HCAP)))
        else $error("row counter beyond height limit");

endmodule

FILE: tb/crop_stream_checker.sv
`timescale 1ns / 1ps
// Checker for the BMP row crop: predicts the cropped byte stream and compares it.
module crop_stream_checker import bmpcrop_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]      cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_pixel_byte,
    input  logic                  s_frame_start,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_out_byte,
    input  logic                  m_is_padding,
    input  logic                  m_row_done,
    input  logic                  m_image_done,
    output int                    n_errors,
    output int                    n_pending,
    output int                    n_results,
    output int                    n_pads,
    output int                    n_images
);

    localparam int unsigned BYTES_PER_PIXEL = 3;
    localparam int unsigned ROW_ALIGN       = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       pad;
        logic       row_end;
        logic       img_end;
    } crop_byte_t;

    logic [DIM_W-1:0] src_width_r, src_height_r, win_width_r, win_height_r;
    logic [POS_W-1:0] win_left_r, win_top_r;
    int unsigned      col_pos, row_pos;
    crop_byte_t       expected_bytes[$];
    crop_byte_t       got, want;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned lim);
        if (v == '0) return 1;
        if (32'(v) > lim) return lim;
        return 32'(v);
    endfunction

    // Advance the row/byte counters by one source byte and queue what it yields.
    function automatic void crop_step(input logic [7:0] b, input logic fs);
        int unsigned sw, sh, line_len, x, y, w, h, ew, lo, hi, lead, tail, npad, k;
        bit          rows_ok, img, row_end;
        sw       = clamp_dim(src_width_r, MAX_WIDTH);
        sh       = clamp_dim(src_height_r, MAX_HEIGHT);
        line_len = sw * BYTES_PER_PIXEL + sw % ROW_ALIGN;
        x        = 32'(win_left_r);
        y        = 32'(win_top_r);
        w        = 32'(win_width_r);
        h        = 32'(win_height_r);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        ew      = (x >= sw) ? 0 : ((w < sw - x) ? w : sw - x);
        rows_ok = (y < sh) && (h != 0) && (ew != 0);
        hi      = rows_ok ? sh - 1 - y : 0;
        lo      = (rows_ok && (y + h < sh)) ? sh - y - h : 0;
        if (rows_ok && row_pos >= lo && row_pos <= hi) begin
            lead = x * BYTES_PER_PIXEL;
            tail = (x + ew) * BYTES_PER_PIXEL - 1;
            if (col_pos >= lead && col_pos <= tail) begin
                npad = ew % ROW_ALIGN;
                img  = (row_pos == hi);
                if (col_pos != tail) begin
                    expected_bytes.push_back({b, 3'b000});
                end else if (npad == 0) begin
                    expected_bytes.push_back({b, 1'b0, 1'b1, img});
                end else begin
                    expected_bytes.push_back({b, 3'b000});
                    for (k = 0; k < npad; k++) begin
                        row_end = (k + 1 == npad);
                        expected_bytes.push_back({8'h00, 1'b1, row_end, row_end & img});
                    end
                end
            end
        end
        col_pos++;
        if (col_pos >= line_len) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= sh) row_pos = 0;
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("[%0t] MISMATCH at result %0d, %s: got %0h, expected %0h",
                 $time, n_results, field, seen, wanted);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            src_width_r  = DIM_W'(1);
            src_height_r = DIM_W'(1);
            win_left_r   = '0;
            win_top_r    = '0;
            win_width_r  = DIM_W'(1);
            win_height_r = DIM_W'(1);
            col_pos      = 0;
            row_pos      = 0;
            expected_bytes.delete();
            n_errors     = 0;
            n_results    = 0;
            n_pads       = 0;
            n_images     = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_out_byte, m_is_padding, m_row_done, m_image_done};
                n_results++;
                if (got.pad === 1'b1) n_pads++;
                if (got.img_end === 1'b1) n_images++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected result", 32'(got), 32'(0));
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data)
                        report_mismatch("out_byte", 32'(got.data), 32'(want.data));
                    if (got.pad !== want.pad)
                        report_mismatch("is_padding", 32'(got.pad), 32'(want.pad));
                    if (got.row_end !== want.row_end)
                        report_mismatch("row_done", 32'(got.row_end), 32'(want.row_end));
                    if (got.img_end !== want.img_end)
                        report_mismatch("image_done", 32'(got.img_end), 32'(want.img_end));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_SOURCE_WIDTH:  src_width_r  = cfg_data;
                    CFG_SOURCE_HEIGHT: src_height_r = cfg_data;
                    CFG_WINDOW_LEFT:   win_left_r   = cfg_data[POS_W-1:0];
                    CFG_WINDOW_TOP:    win_top_r    = cfg_data[POS_W-1:0];
                    CFG_WINDOW_WIDTH:  win_width_r  = cfg_data;
                    CFG_WINDOW_HEIGHT: win_height_r = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) crop_step(s_pixel_byte, s_frame_start);
        end
        n_pending <= expected_bytes.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the BMP row crop: stimulus, flow control and verdict.
module tb;
    import bmpcrop_pkg::*;

    localparam int          MAX_WIDTH       = 4096;
    localparam int          MAX_HEIGHT      = 4096;
    localparam int unsigned BYTES_PER_PIXEL = 3;
    localparam int unsigned ROW_ALIGN       = 4;
    localparam int unsigned DIM_MAX         = (1 << DIM_W) - 1;
    localparam int unsigned DRAIN_CYCLES    = 8;     // input and output registers plus up to 3 padding bytes
    localparam int unsigned HOLD_CYCLES     = 200;   // long receiver hold-off
    localparam int unsigned RANDOM_ITEMS    = 100;
    localparam int unsigned RANDOM_RESULTS  = 48;
    localparam int unsigned MAX_PHASES      = 40;
    localparam int unsigned NO_PAUSE        = 32'hFFFF_FFFF;
    localparam int unsigned LIMIT_NS        = 5_000_000;
    // Index past the end of the register list; a write there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DIM_W-1:0]      cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_pixel_byte;
    logic                  s_frame_start;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_out_byte;
    logic                  m_is_padding;
    logic                  m_row_done;
    logic                  m_image_done;

    int          n_errors, n_pending, n_results, n_pads, n_images;
    int unsigned src_bytes;
    int unsigned n_geoms;
    // Flow-control knobs shared between the stimulus and the receiver process.
    bit          s_idle_on;
    bit          rx_stall_on;
    bit          rx_hold_req;

    bmp_row_padded_crop #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_byte  (s_pixel_byte),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_padding  (m_is_padding),
        .m_row_done    (m_row_done),
        .m_image_done  (m_image_done)
    );

    crop_stream_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_byte  (s_pixel_byte),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_padding  (m_is_padding),
        .m_row_done    (m_row_done),
        .m_image_done  (m_image_done),
        .n_errors      (n_errors),
        .n_pending     (n_pending),
        .n_results     (n_results),
        .n_pads        (n_pads),
        .n_images      (n_images)
    );

    // 2 ns clock, low first so the first rising edge lands at 1 ns.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int unsigned gap_len(input bit enabled);
        int unsigned r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Window origin: usually inside or just on the source edge, sometimes far out.
    function automatic logic [DIM_W-1:0] pick_origin(input int unsigned span);
        if ($urandom_range(0, 9) < 7) return DIM_W'($urandom_range(0, span));
        return DIM_W'($urandom_range(0, DIM_MAX));
    endfunction

    // Window extent: sometimes empty, usually near the source size, sometimes huge.
    function automatic logic [DIM_W-1:0] pick_extent(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 8) return DIM_W'($urandom_range(1, span + 1));
        return DIM_W'($urandom_range(1, DIM_MAX));
    endfunction

    // Hold cfg_valid across back-to-back writes; the caller drops it after the last one.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Wait until every predicted byte has come out, then let the pipeline settle,
    // since a trailing byte may produce nothing and still be in flight.
    task automatic wait_idle();
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Reprogram all six registers; only ever done with the block idle.
    task automatic set_geometry(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y,
                                input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        cfg_write(CFG_SOURCE_WIDTH, sw);
        cfg_write(CFG_SOURCE_HEIGHT, sh);
        cfg_write(CFG_WINDOW_LEFT, x);
        cfg_write(CFG_WINDOW_TOP, y);
        cfg_write(CFG_WINDOW_WIDTH, w);
        cfg_write(CFG_WINDOW_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Offer one source byte and hold it until the transaction completes. Valid is
    // left high so that a following byte can go out on the very next edge.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        s_valid       <= 1'b1;
        s_pixel_byte  <= b;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        src_bytes++;
    endtask

    // Stream a run of source bytes. The first byte may start a frame; in noisy
    // runs a stray frame start can also land mid-frame. At pause_at the sender
    // stops and waits for the output to drain completely before going on.
    task automatic stream_bytes(input int unsigned count, input bit lead_start,
                                input bit extremes, input bit noisy,
                                input int unsigned pause_at);
        int unsigned i, gap;
        logic        fs;
        logic [7:0]  b;
        for (i = 0; i < count; i++) begin
            fs = (i == 0) ? lead_start : (noisy && $urandom_range(0, 63) == 0);
            b  = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
            send_byte(b, fs);
            gap = gap_len(s_idle_on);
            if (i == pause_at) begin
                s_valid <= 1'b0;
                wait_idle();
            end else if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    // One random geometry on a tiny source, then one or two frames of data.
    // Zero source dimensions show up now and then to hit the treat-as-one rule;
    // a frame without a leading frame start continues from stale counters.
    task automatic random_phase(input bit with_pause);
        int unsigned sw, sh, eff_w, eff_h, count;
        sw    = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
        sh    = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
        eff_w = (sw == 0) ? 1 : sw;
        eff_h = (sh == 0) ? 1 : sh;
        set_geometry(DIM_W'(sw), DIM_W'(sh), pick_origin(eff_w), pick_origin(eff_h),
                     pick_extent(eff_w), pick_extent(eff_h));
        s_idle_on   = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
        count = (eff_w * BYTES_PER_PIXEL + eff_w % ROW_ALIGN) * eff_h * $urandom_range(1, 2);
        stream_bytes(count, $urandom_range(0, 9) != 0, 1'b0, 1'b1,
                     with_pause ? count / 2 : NO_PAUSE);
        n_geoms++;
    endtask

    // Receiver: alternate ready runs and stalls, or ride out a requested
    // long hold-off, counted here in its own process.
    initial begin : rx_drive
        int unsigned n;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                n = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (!rx_stall_on || $urandom_range(0, 1) != 0) begin
                n = $urandom_range(1, 12);
                m_ready <= 1'b1;
            end else begin
                n = gap_len(1'b1) + 1;
                m_ready <= 1'b0;
            end
            repeat (n) @(posedge aclk);
        end
    end

    initial begin : main_seq
        int unsigned phase, rand_base, rand_results;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_addr      <= CFG_SOURCE_WIDTH;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_pixel_byte  <= 8'h00;
        s_frame_start <= 1'b0;
        src_bytes     = 0;
        n_geoms       = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. A write to an index past the register list goes first;
        // the reset geometry (1 x 1 source and window) must still hold after it.
        cfg_write(CFG_UNUSED, DIM_W'(DIM_MAX));
        cfg_valid   <= 1'b0;
        s_idle_on   = 1'b1;
        rx_stall_on = 1'b1;
        stream_bytes(4, 1'b1, 1'b1, 1'b0, NO_PAUSE);

        // Window wider and taller than the source: clipped to 3 pixels of the
        // bottom row, so the last pixel byte yields the byte plus three pads.
        set_geometry(3, 2, 0, 1, 4, 5);
        stream_bytes(12, 1'b1, 1'b1, 1'b0, NO_PAUSE);

        // Zero source width counts as one pixel; two output rows, the top one
        // ends the image.
        set_geometry(0, 2, 0, 0, 1, 2);
        stream_bytes(8, 1'b1, 1'b1, 1'b0, NO_PAUSE);

        // Back-pressure: every source byte passes while the receiver holds off,
        // so the block fills and stalls the sender.
        set_geometry(4, 4, 0, 0, 4, 4);
        s_idle_on   = 1'b0;
        rx_hold_req = 1'b1;
        stream_bytes(48, 1'b1, 1'b0, 1'b0, NO_PAUSE);

        // Largest settings: source dimensions saturate to the limits, and the
        // window row is the last one counted from the top, which is the first
        // row stored. The leading pixels of that row come out.
        set_geometry(DIM_W'(DIM_MAX), DIM_W'(DIM_MAX), '0, DIM_W'(MAX_HEIGHT - 1),
                     DIM_W'(DIM_MAX), DIM_W'(DIM_MAX));
        rx_stall_on = 1'b0;
        stream_bytes(24, 1'b1, 1'b0, 1'b0, NO_PAUSE);

        // Random part on small geometries until enough bytes and results have passed.
        rand_base    = src_bytes;
        rand_results = n_results;
        phase        = 0;
        while (phase < MAX_PHASES &&
               (src_bytes - rand_base < RANDOM_ITEMS ||
                n_results - rand_results < RANDOM_RESULTS)) begin
            random_phase(phase == 0);
            phase++;
        end

        wait_idle();
        $display("Run covered %0d source bytes over %0d random geometries plus directed cases",
                 src_bytes, n_geoms);
        $display("Output checked: %0d bytes, %0d of them row padding, %0d image ends",
                 n_results, n_pads, n_images);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: a stuck handshake or a missing result ends the run here.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("Timeout with %0d results still outstanding", n_pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
